// ----- rtl/core/vps_pkg.sv -----
// Shared types, command codes and built-in notification tables of the vibration sequencer.
`timescale 1ns / 1ps

package vps_pkg;

    // Command kinds carried by the kind field.
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_CONT    = 3'd1;
    localparam logic [2:0] KIND_STOP    = 3'd2;
    localparam logic [2:0] KIND_TIMED   = 3'd3;
    localparam logic [2:0] KIND_BURST   = 3'd4;
    localparam logic [2:0] KIND_STEP    = 3'd5;
    localparam logic [2:0] KIND_NOTIFY  = 3'd6;

    // One command item as it is taken from the input channel.
    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        on_ms;
        logic [15:0]        off_ms;
        logic [15:0]        burst_count;
        logic signed [16:0] step_ms;
        logic               last_step;
        logic [3:0]         notice;
    } vps_cmd_t;

    // One result item.
    typedef struct packed {
        logic motor_on;
        logic busy_res;
        logic accepted;
        logic finished;
    } vps_res_t;

    // Table entries: positive is an on step, negative an off step, in milliseconds.
    typedef logic signed [11:0] note_ms_t;

    localparam int NOTE_ROWS = 15;
    localparam int NOTE_COLS = 16;

    localparam note_ms_t NZ = 12'sd0;

    localparam note_ms_t NOTE_TABLE [NOTE_ROWS][NOTE_COLS] = '{
        '{12'sd100, -12'sd100, 12'sd100, -12'sd100, 12'sd100, NZ, NZ, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd1300, -12'sd1000, 12'sd1300, -12'sd1000, 12'sd1300, -12'sd1000, NZ, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd100, -12'sd100, 12'sd100, -12'sd500, 12'sd100, -12'sd100, 12'sd100, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd500, -12'sd200, 12'sd500, -12'sd200, 12'sd500, NZ, NZ, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd300, -12'sd100, NZ, NZ, NZ, NZ, NZ, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd300, -12'sd100, 12'sd200, -12'sd100, 12'sd100, -12'sd100, NZ, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd300, -12'sd100, 12'sd300, -12'sd100, 12'sd300, -12'sd500, 12'sd300, -12'sd100,
          12'sd300, -12'sd100, 12'sd300, NZ, NZ, NZ, NZ, NZ},
        '{12'sd100, -12'sd50, 12'sd100, -12'sd50, 12'sd100, -12'sd50, 12'sd100, -12'sd50,
          12'sd100, -12'sd50, 12'sd100, -12'sd50, NZ, NZ, NZ, NZ},
        '{12'sd200, -12'sd100, 12'sd200, -12'sd100, 12'sd200, -12'sd300, 12'sd200, -12'sd100,
          12'sd200, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{12'sd300, -12'sd300, 12'sd100, NZ, NZ, NZ, NZ, NZ,
          NZ, NZ, NZ, NZ, NZ, NZ, NZ, NZ},
        '{NOTE_COLS{NZ}},
        '{NOTE_COLS{NZ}},
        '{NOTE_COLS{NZ}},
        '{NOTE_COLS{NZ}},
        '{NOTE_COLS{NZ}}
    };

    // Number of steps in each table row.
    localparam logic [4:0] NOTE_LEN [NOTE_ROWS] = '{
        5'd5, 5'd6, 5'd7, 5'd5, 5'd2, 5'd6, 5'd11, 5'd12, 5'd9, 5'd3,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };

endpackage

// ----- rtl/core/vps_cmd_if.sv -----
// Command channel interface of the vibration sequencer.
`timescale 1ns / 1ps

interface vps_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [15:0]        on_ms;
    logic [15:0]        off_ms;
    logic [15:0]        burst_count;
    logic signed [16:0] step_ms;
    logic               last_step;
    logic [3:0]         notice;

    modport source (
        output valid, kind, on_ms, off_ms, burst_count, step_ms, last_step, notice,
        input  ready
    );

    modport sink (
        input  valid, kind, on_ms, off_ms, burst_count, step_ms, last_step, notice,
        output ready
    );
endinterface

// ----- rtl/core/vps_res_if.sv -----
// Result channel interface of the vibration sequencer.
`timescale 1ns / 1ps

interface vps_res_if;
    logic valid;
    logic ready;
    logic motor_on;
    logic busy_res;
    logic accepted;
    logic finished;

    modport source (
        output valid, motor_on, busy_res, accepted, finished,
        input  ready
    );

    modport sink (
        input  valid, motor_on, busy_res, accepted, finished,
        output ready
    );
endinterface

// ----- rtl/core/vps_step.sv -----
// Activity state registers and the combinational update for one command or tick.
`timescale 1ns / 1ps

module vps_step #(
    parameter int PATTERN_COUNT     = 10,
    parameter int MAX_PATTERN_STEPS = 12,
    parameter int DURATION_BITS     = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_fire,
    input  vps_pkg::vps_cmd_t cmd_data,
    output vps_pkg::vps_res_t res_data
);
    import vps_pkg::*;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_TIMED = 5'b00010,
        MODE_BURST = 5'b00100,
        MODE_STEP  = 5'b01000,
        MODE_NOTE  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic                     level;
        logic [DURATION_BITS-1:0] dur;
    } step_load_t;

    localparam int               SW     = (DURATION_BITS > 17) ? DURATION_BITS : 17;
    localparam logic [SW-1:0]    DMAX_W = SW'({DURATION_BITS{1'b1}});
    localparam logic [3:0]       PCOUNT = 4'(PATTERN_COUNT);
    localparam logic [4:0]       MSTEPS = 5'(MAX_PATTERN_STEPS);

    // Saturate a duration to the largest value the phase counter holds.
    function automatic logic [DURATION_BITS-1:0] sat_dur(input logic [16:0] v);
        logic [SW-1:0] vw;
        begin
            vw = SW'(v);
            if (vw > DMAX_W)
                sat_dur = DURATION_BITS'(DMAX_W);
            else
                sat_dur = DURATION_BITS'(vw);
        end
    endfunction

    // Table length of a notification, zero where there is no table.
    function automatic logic [4:0] note_length(input logic [3:0] n);
        logic [4:0] len;
        begin
            if (n == 4'd0 || n > PCOUNT)
            begin
                len = 5'd0;
            end
            else
            begin
                len = NOTE_LEN[n - 4'd1];
                if (len > MSTEPS)
                    len = MSTEPS;
            end
            note_length = len;
        end
    endfunction

    // Level and duration of one table step.
    function automatic step_load_t note_load(input logic [3:0] num, input logic [3:0] pos);
        note_ms_t   e;
        logic [10:0] mag;
        step_load_t r;
        begin
            e = NOTE_TABLE[num - 4'd1][pos];
            if (e > 12'sd0)
            begin
                r.level = 1'b1;
                mag     = e[10:0];
            end
            else
            begin
                r.level = 1'b0;
                mag     = 11'(-e);
            end
            r.dur = sat_dur({6'd0, mag});
            note_load = r;
        end
    endfunction

    mode_t                    mode_reg,  mode_next;
    logic [DURATION_BITS-1:0] phase_reg, phase_next;
    logic [15:0]              reps_reg,  reps_next;
    logic [DURATION_BITS-1:0] on_reg,    on_next;
    logic [DURATION_BITS-1:0] off_reg,   off_next;
    logic [3:0]               pnum_reg,  pnum_next;
    logic [3:0]               ppos_reg,  ppos_next;
    logic                     level_reg, level_next;
    logic                     last_reg,  last_next;

    logic                     busy;
    logic                     acc;
    logic                     fin;
    logic                     adv;
    logic [DURATION_BITS-1:0] phase_dec;
    logic [16:0]              step_mag;
    logic [4:0]               npos;
    step_load_t               ld;

    assign busy = (mode_reg != MODE_IDLE);

    // Command or tick, then the walk past any phase that has run out.
    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        reps_next  = reps_reg;
        on_next    = on_reg;
        off_next   = off_reg;
        pnum_next  = pnum_reg;
        ppos_next  = ppos_reg;
        level_next = level_reg;
        last_next  = last_reg;
        acc        = 1'b0;
        fin        = 1'b0;
        adv        = 1'b0;
        npos       = 5'd0;
        ld         = '0;
        phase_dec  = (phase_reg == '0) ? phase_reg : phase_reg - 1'b1;
        step_mag   = cmd_data.step_ms[16] ? 17'(~cmd_data.step_ms + 17'sd1)
                                          : 17'(cmd_data.step_ms);

        if (cmd_data.kind == KIND_TICK)
        begin
            if (busy)
            begin
                phase_next = phase_dec;
                adv        = (phase_dec == '0);
            end
        end
        else if (!busy)
        begin
            case (cmd_data.kind)
                KIND_CONT:
                begin
                    acc        = 1'b1;
                    level_next = 1'b1;
                end
                KIND_STOP:
                begin
                    acc        = 1'b1;
                    level_next = 1'b0;
                end
                KIND_TIMED:
                begin
                    acc        = 1'b1;
                    level_next = 1'b1;
                    mode_next  = MODE_TIMED;
                    phase_next = sat_dur({1'b0, cmd_data.on_ms});
                    adv        = (phase_next == '0);
                end
                KIND_BURST:
                begin
                    acc       = 1'b1;
                    on_next   = sat_dur({1'b0, cmd_data.on_ms});
                    off_next  = sat_dur({1'b0, cmd_data.off_ms});
                    reps_next = cmd_data.burst_count;
                    if (cmd_data.burst_count == 16'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        mode_next  = MODE_BURST;
                        ppos_next  = 4'd0;
                        level_next = 1'b1;
                        phase_next = on_next;
                        adv        = (on_next == '0);
                    end
                end
                KIND_STEP:
                begin
                    acc        = 1'b1;
                    level_next = !cmd_data.step_ms[16] && (cmd_data.step_ms != 17'sd0);
                    last_next  = cmd_data.last_step;
                    mode_next  = MODE_STEP;
                    phase_next = sat_dur(step_mag);
                    adv        = (phase_next == '0);
                end
                KIND_NOTIFY:
                begin
                    acc = 1'b1;
                    if (note_length(cmd_data.notice) == 5'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        ld         = note_load(cmd_data.notice, 4'd0);
                        pnum_next  = cmd_data.notice;
                        ppos_next  = 4'd0;
                        mode_next  = MODE_NOTE;
                        level_next = ld.level;
                        phase_next = ld.dur;
                        adv        = (ld.dur == '0);
                    end
                end
                default:
                begin
                    acc = 1'b0;
                end
            endcase
        end

        // A phase has ended: move to the next one of nonzero length, or finish.
        if (adv)
        begin
            case (mode_next)
                MODE_TIMED:
                begin
                    level_next = 1'b0;
                    mode_next  = MODE_IDLE;
                    fin        = 1'b1;
                end
                MODE_BURST:
                begin
                    if (ppos_next == 4'd0 && off_next != '0)
                    begin
                        // On time over: start the pause.
                        level_next = 1'b0;
                        ppos_next  = 4'd1;
                        phase_next = off_next;
                    end
                    else if (reps_next == 16'd1)
                    begin
                        // Last cycle done.
                        if (ppos_next == 4'd0)
                            level_next = 1'b0;
                        reps_next = 16'd0;
                        ppos_next = 4'd1;
                        mode_next = MODE_IDLE;
                        fin       = 1'b1;
                    end
                    else if (on_next != '0)
                    begin
                        // Next cycle starts with its on time.
                        reps_next  = reps_next - 16'd1;
                        level_next = 1'b1;
                        ppos_next  = 4'd0;
                        phase_next = on_next;
                    end
                    else if (ppos_next == 4'd1 && off_next != '0)
                    begin
                        // Empty on time: straight into the next pause.
                        reps_next  = reps_next - 16'd1;
                        level_next = 1'b0;
                        ppos_next  = 4'd1;
                        phase_next = off_next;
                    end
                    else
                    begin
                        // Every remaining phase is empty.
                        reps_next  = 16'd0;
                        level_next = 1'b0;
                        ppos_next  = 4'd1;
                        mode_next  = MODE_IDLE;
                        fin        = 1'b1;
                    end
                end
                MODE_STEP:
                begin
                    mode_next = MODE_IDLE;
                    fin       = last_next;
                end
                MODE_NOTE:
                begin
                    npos = {1'b0, ppos_next} + 5'd1;
                    if (npos >= note_length(pnum_next))
                    begin
                        mode_next = MODE_IDLE;
                        fin       = 1'b1;
                    end
                    else
                    begin
                        ld         = note_load(pnum_next, npos[3:0]);
                        ppos_next  = npos[3:0];
                        level_next = ld.level;
                        phase_next = ld.dur;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Result of this item, taken from the updated state.
    always_comb
    begin
        res_data.motor_on = level_next;
        res_data.busy_res = (mode_next != MODE_IDLE);
        res_data.accepted = acc;
        res_data.finished = fin;
    end

    // State registers advance on every transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= '0;
            reps_reg  <= 16'd0;
            on_reg    <= '0;
            off_reg   <= '0;
            pnum_reg  <= 4'd0;
            ppos_reg  <= 4'd0;
            level_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (cmd_fire)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            reps_reg  <= reps_next;
            on_reg    <= on_next;
            off_reg   <= off_next;
            pnum_reg  <= pnum_next;
            ppos_reg  <= ppos_next;
            level_reg <= level_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- rtl/core/vps_res_buf.sv -----
// Two-entry result buffer that decouples the command side from the result side.
`timescale 1ns / 1ps

module vps_res_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vps_pkg::vps_res_t push_data,
    input  logic              pop_ready,
    output logic              head_valid,
    output vps_pkg::vps_res_t head_data,
    output logic              full
);
    import vps_pkg::*;

    logic [1:0] count_reg, count_next;
    vps_res_t   slot0_reg, slot0_next;
    vps_res_t   slot1_reg, slot1_next;
    logic       pop;

    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot0_reg;
    assign full       = (count_reg == 2'd2);
    assign pop        = head_valid && pop_ready;

    // Fill and drain; the head entry is always slot 0.
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ----- rtl/core/vibration_pattern_sequencer.sv -----
// Top level of the vibration sequencer: command channel in, one result per command out.
//
//   Channel  Direction  Payload
//   cmd      in         kind, on_ms, off_ms, burst_count, step_ms, last_step, notice
//   res      out        motor_on, busy_res, accepted, finished
//
// One item per clock cycle while cmd.ready is high: each transfer updates the registered activity state.
// The result of an item is registered into a two-entry buffer and presented once earlier results are taken.
// cmd.ready falls only while both buffer entries hold results that res has not taken.
// rst_n clears the activity to idle with the motor off and empties the buffer.
`timescale 1ns / 1ps

module vibration_pattern_sequencer #(
    parameter int PATTERN_COUNT     = 10,
    parameter int MAX_PATTERN_STEPS = 12,
    parameter int DURATION_BITS     = 16
) (
    input logic       clk,
    input logic       rst_n,
    vps_cmd_if.sink   cmd,
    vps_res_if.source res
);
    import vps_pkg::*;

    vps_cmd_t cmd_data;
    vps_res_t step_res;
    vps_res_t head_data;
    logic     cmd_fire;
    logic     buf_full;
    logic     head_valid;

    // Command transfer.
    assign cmd.ready = !buf_full;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_data.kind        = cmd.kind;
        cmd_data.on_ms       = cmd.on_ms;
        cmd_data.off_ms      = cmd.off_ms;
        cmd_data.burst_count = cmd.burst_count;
        cmd_data.step_ms     = cmd.step_ms;
        cmd_data.last_step   = cmd.last_step;
        cmd_data.notice      = cmd.notice;
    end

    vps_step #(
        .PATTERN_COUNT     (PATTERN_COUNT),
        .MAX_PATTERN_STEPS (MAX_PATTERN_STEPS),
        .DURATION_BITS     (DURATION_BITS)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_fire (cmd_fire),
        .cmd_data (cmd_data),
        .res_data (step_res)
    );

    vps_res_buf u_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_fire),
        .push_data  (step_res),
        .pop_ready  (res.ready),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (buf_full)
    );

    // Result transfer.
    assign res.valid    = head_valid;
    assign res.motor_on = head_data.motor_on;
    assign res.busy_res = head_data.busy_res;
    assign res.accepted = head_data.accepted;
    assign res.finished = head_data.finished;

endmodule

// ----- rtl/core/vps_checker.sv -----
// Port-level checks of the vibration sequencer, bound to its top level.
`timescale 1ns / 1ps

module vps_checker (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_motor_on,
    input logic res_busy_res,
    input logic res_accepted,
    input logic res_finished
);

    // A stalled result keeps its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({res_motor_on, res_busy_res, res_accepted, res_finished}))
        else $error("result changed while stalled");

    // Every command transfer leaves a result waiting on the next cycle.
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("no result after a command transfer");

    // With no result waiting the block must take commands.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> cmd_ready)
        else $error("command side stalled with empty result buffer");

    // A finished activity leaves the block idle.
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_finished |-> !res_busy_res)
        else $error("finished reported while still busy");

endmodule

bind vibration_pattern_sequencer vps_checker u_vps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_motor_on (res.motor_on),
    .res_busy_res (res.busy_res),
    .res_accepted (res.accepted),
    .res_finished (res.finished)
);
